@@ design/dqs_pkg.sv @@
`default_nettype none

package dqs_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned StatW = 3;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_DUMP       = 3'd6
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_FOUND    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

endpackage

`default_nettype wire

@@ design/dqs_ram.sv @@
`default_nettype none

module dqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/double_ended_queue_with_search.sv @@
`default_nettype none

// Bounded deque of signed 32-bit values held in a ring of DEPTH entries in a
// single-port-read RAM with registered read. A command is taken when start is
// high and busy is low. Push, clear and an unused op code leave busy low; their
// result appears the next cycle. A pop reads the RAM as it is taken and shows
// the read item from S_POP. Search and dump walk the stored entries through the
// RAM read port, one entry per cycle; search checks each in one 32-bit comparator
// and stops at the first match. Dump issues one result per stored entry on
// consecutive cycles, front to back, last_o on the final one. Every result is
// shown for exactly one cycle with res_valid_o high; the receiver cannot stall
// it, so results must be captured as they appear.
module double_ended_queue_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [dqs_pkg::OpW-1:0]      op_i,
  input  wire logic signed [dqs_pkg::DataW-1:0]    value_i,
  output logic                                     res_valid_o,
  output logic             [dqs_pkg::StatW-1:0]    status_o,
  output logic signed      [dqs_pkg::DataW-1:0]    item_o,
  output logic                                     last_o
);

  import dqs_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = IW + 1;
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);
  localparam logic [SW-1:0] DepthS  = SW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WALK
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     front_q, front_d;
  logic [CW-1:0]     occ_q, occ_d;
  logic [IW-1:0]     addr_q, addr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  op_e               op_q, op_d;
  logic [DataW-1:0]  val_q, val_d;
  logic              res_valid_q, res_valid_d;
  status_e           res_status_q, res_status_d;
  logic [DataW-1:0]  res_item_q, res_item_d;
  logic              res_last_q, res_last_d;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [IW-1:0]     ram_raddr;
  logic [DataW-1:0]  ram_rdata;

  logic [IW-1:0]     front_inc, front_dec, addr_inc, tail_pos, back_pos;
  logic [SW-1:0]     tail_sum, back_sum;
  logic              is_full, is_empty, walk_final, hit;

  assign front_inc = (front_q == LastIdx) ? '0 : front_q + IW'(1);
  assign front_dec = (front_q == '0) ? LastIdx : front_q - IW'(1);
  assign addr_inc  = (addr_q == LastIdx) ? '0 : addr_q + IW'(1);
  assign tail_sum  = SW'(front_q) + SW'(occ_q);
  assign back_sum  = tail_sum - SW'(1);
  assign tail_pos  = (tail_sum >= DepthS) ? IW'(tail_sum - DepthS) : IW'(tail_sum);
  assign back_pos  = (back_sum >= DepthS) ? IW'(back_sum - DepthS) : IW'(back_sum);
  assign is_full   = (occ_q == FullCnt);
  assign is_empty  = (occ_q == '0);
  assign walk_final = ((cnt_q + CW'(1)) == occ_q);
  assign hit        = (ram_rdata == val_q);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    occ_d        = occ_q;
    addr_d       = addr_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    val_d        = val_q;
    res_valid_d  = 1'b0;
    res_status_d = STAT_OK;
    res_item_d   = '0;
    res_last_d   = 1'b1;
    ram_we       = 1'b0;
    ram_waddr    = front_dec;
    ram_raddr    = addr_q;

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = (op_e'(op_i) == OP_POP_BACK) ? back_pos : front_q;
        if (start) begin
          op_d  = op_e'(op_i);
          val_d = value_i;
          unique case (op_e'(op_i))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              res_valid_d = 1'b1;
              if (is_full) begin
                res_status_d = STAT_FULL;
              end else begin
                ram_we = 1'b1;
                occ_d  = occ_q + CW'(1);
                if (op_e'(op_i) == OP_PUSH_FRONT) begin
                  ram_waddr = front_dec;
                  front_d   = front_dec;
                end else begin
                  ram_waddr = tail_pos;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                res_valid_d  = 1'b1;
                res_status_d = STAT_EMPTY;
              end else begin
                occ_d   = occ_q - CW'(1);
                state_d = S_POP;
                if (op_e'(op_i) == OP_POP_FRONT) begin
                  front_d = front_inc;
                end
              end
            end
            OP_SEARCH, OP_DUMP: begin
              if (is_empty) begin
                res_valid_d  = 1'b1;
                res_status_d = (op_e'(op_i) == OP_SEARCH) ? STAT_NOTFOUND : STAT_EMPTY;
              end else begin
                addr_d  = front_inc;
                cnt_d   = '0;
                state_d = S_WALK;
              end
            end
            OP_CLEAR: begin
              front_d     = '0;
              occ_d       = '0;
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        res_valid_d = 1'b1;
        res_item_d  = ram_rdata;
        state_d     = S_IDLE;
      end
      S_WALK: begin
        addr_d = addr_inc;
        cnt_d  = cnt_q + CW'(1);
        if (op_q == OP_SEARCH) begin
          if (hit) begin
            res_valid_d  = 1'b1;
            res_status_d = STAT_FOUND;
            state_d      = S_IDLE;
          end else if (walk_final) begin
            res_valid_d  = 1'b1;
            res_status_d = STAT_NOTFOUND;
            state_d      = S_IDLE;
          end
        end else begin
          res_valid_d = 1'b1;
          res_item_d  = ram_rdata;
          res_last_d  = walk_final;
          if (walk_final) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      front_q      <= '0;
      occ_q        <= '0;
      addr_q       <= '0;
      cnt_q        <= '0;
      op_q         <= OP_PUSH_FRONT;
      res_valid_q  <= 1'b0;
      res_status_q <= STAT_OK;
      res_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      occ_q        <= occ_d;
      addr_q       <= addr_d;
      cnt_q        <= cnt_d;
      op_q         <= op_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    res_item_q <= res_item_d;
  end

  dqs_ram #(
    .Width (DataW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_d),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign status_o    = res_status_q;
  assign item_o      = res_item_q;
  assign last_o      = res_last_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FullCnt)
    else $error("occupancy above depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && is_full &&
     (op_i == OP_PUSH_FRONT || op_i == OP_PUSH_BACK))
    |=> (res_valid_o && status_o == STAT_FULL && $stable(occ_q)))
    else $error("push on full queue not dropped");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy)
    else $error("non-final result while idle");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cnt_q < occ_q))
    else $error("walk past stored entries");
`endif

endmodule

`default_nettype wire

@@ test/double_ended_queue_with_search_test.sv @@
`timescale 1ns / 100ps

module double_ended_queue_with_search_test;
  import dqs_pkg::*;

  localparam int Depth = 16;
  localparam int RandomItems = 300;
  localparam int IdleLimit = 2000;
  localparam int MaxReports = 10;
  localparam logic [OpW-1:0] OpUnused = 3'd7;

  typedef struct packed {
    status_e status;
    logic [DataW-1:0] item;
    logic last;
  } deque_result_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [DataW-1:0] value;
    logic [4:0] reps;
    logic typed;
    status_e status;
    logic [DataW-1:0] item;
  } cmd_row_t;

  localparam int NumRows = 17;
  localparam cmd_row_t CmdTable [NumRows] = '{
    '{OP_POP_FRONT, 32'h0000_0000, 5'd1, 1'b1, STAT_EMPTY, 32'h0},
    '{OP_POP_BACK, 32'hFFFF_FFFF, 5'd1, 1'b1, STAT_EMPTY, 32'h0},
    '{OP_DUMP, 32'h0000_0000, 5'd1, 1'b1, STAT_EMPTY, 32'h0},
    '{OP_SEARCH, 32'h0000_0000, 5'd1, 1'b1, STAT_NOTFOUND, 32'h0},
    '{OpUnused, 32'hFFFF_FFFF, 5'd1, 1'b1, STAT_OK, 32'h0},
    '{OP_PUSH_BACK, 32'h7FFF_FFFF, 5'd1, 1'b1, STAT_OK, 32'h0},
    '{OP_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1, STAT_OK, 32'h0},
    '{OP_SEARCH, 32'h8000_0000, 5'd1, 1'b1, STAT_FOUND, 32'h0},
    '{OP_POP_BACK, 32'h0000_0000, 5'd1, 1'b1, STAT_OK, 32'h7FFF_FFFF},
    '{OP_POP_FRONT, 32'h0000_0000, 5'd1, 1'b1, STAT_OK, 32'h8000_0000},
    '{OP_PUSH_FRONT, 32'hAAAA_0000, 5'd16, 1'b1, STAT_OK, 32'h0},
    '{OP_PUSH_BACK, 32'h1234_5678, 5'd1, 1'b1, STAT_FULL, 32'h0},
    '{OP_PUSH_FRONT, 32'h1234_5678, 5'd1, 1'b1, STAT_FULL, 32'h0},
    '{OP_SEARCH, 32'hAAAA_0000, 5'd1, 1'b1, STAT_FOUND, 32'h0},
    '{OP_DUMP, 32'h0000_0000, 5'd1, 1'b0, STAT_OK, 32'h0},
    '{OP_CLEAR, 32'h0000_0000, 5'd1, 1'b1, STAT_OK, 32'h0},
    '{OP_DUMP, 32'h0000_0000, 5'd1, 1'b1, STAT_EMPTY, 32'h0}
  };

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [OpW-1:0] op_i;
  logic signed [DataW-1:0] value_i;
  logic res_valid_o;
  logic [StatW-1:0] status_o;
  logic signed [DataW-1:0] item_o;
  logic last_o;

  logic [DataW-1:0] ring_store [Depth];
  int ring_head;
  int ring_fill;
  deque_result_t step_results [$];
  deque_result_t pending_results [$];
  int fail_count;
  int idle_cycles;
  int burst_left;

  double_ended_queue_with_search #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .op_i(op_i),
    .value_i(value_i),
    .res_valid_o(res_valid_o),
    .status_o(status_o),
    .item_o(item_o),
    .last_o(last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void add_result(status_e status, logic [DataW-1:0] item, logic last);
    deque_result_t res;
    res.status = status;
    res.item = item;
    res.last = last;
    step_results.push_back(res);
  endfunction

  function automatic void deque_step(logic [OpW-1:0] op, logic [DataW-1:0] value);
    bit hit;
    hit = 1'b0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_fill >= Depth) begin
          add_result(STAT_FULL, '0, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            ring_head = (ring_head + Depth - 1) % Depth;
            ring_store[ring_head] = value;
          end else begin
            ring_store[(ring_head + ring_fill) % Depth] = value;
          end
          ring_fill++;
          add_result(STAT_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT: begin
        if (ring_fill == 0) begin
          add_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          add_result(STAT_OK, ring_store[ring_head], 1'b1);
          ring_head = (ring_head + 1) % Depth;
          ring_fill--;
        end
      end
      OP_POP_BACK: begin
        if (ring_fill == 0) begin
          add_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          ring_fill--;
          add_result(STAT_OK, ring_store[(ring_head + ring_fill) % Depth], 1'b1);
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < ring_fill; i++) begin
          if (ring_store[(ring_head + i) % Depth] == value) hit = 1'b1;
        end
        add_result(hit ? STAT_FOUND : STAT_NOTFOUND, '0, 1'b1);
      end
      OP_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
        add_result(STAT_OK, '0, 1'b1);
      end
      OP_DUMP: begin
        if (ring_fill == 0) begin
          add_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < ring_fill; i++) begin
            add_result(STAT_OK, ring_store[(ring_head + i) % Depth], i == ring_fill - 1);
          end
        end
      end
      default: begin
        add_result(STAT_OK, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic issue_command(logic [OpW-1:0] op, logic [DataW-1:0] value, logic typed,
                               status_e status, logic [DataW-1:0] item);
    int gap;
    deque_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        op_i <= OpW'($urandom);
        value_i <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    op_i <= op;
    value_i <= value;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    step_results.delete();
    deque_step(op, value);
    if (typed) begin
      res.status = status;
      res.item = item;
      res.last = 1'b1;
      pending_results.push_back(res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    deque_result_t exp_res;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("unexpected transaction: status %0d item %h last %0d",
                   status_o, item_o, last_o);
        end
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status || item_o !== exp_res.item ||
            last_o !== exp_res.last) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("mismatch: status exp %0d got %0d, item exp %h got %h, last exp %0d got %0d",
                     exp_res.status, status_o, exp_res.item, item_o, exp_res.last, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int push_pct;
    int r;
    logic [OpW-1:0] op;
    logic [DataW-1:0] value;
    rst_ni = 1'b0;
    start = 1'b0;
    op_i = '0;
    value_i = '0;
    ring_head = 0;
    ring_fill = 0;
    fail_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    push_pct = 50;
    foreach (ring_store[i]) ring_store[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (CmdTable[row]) begin
      for (int k = 0; k < CmdTable[row].reps; k++) begin
        issue_command(CmdTable[row].op, CmdTable[row].value + k, CmdTable[row].typed,
                      CmdTable[row].status, CmdTable[row].item);
      end
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      r = $urandom_range(99);
      value = pick_value();
      if (r < 3) begin
        op = OpUnused;
      end else if (r < 6) begin
        op = OP_CLEAR;
      end else if (r < 14) begin
        op = OP_DUMP;
      end else if (r < 28) begin
        op = OP_SEARCH;
        if (ring_fill > 0 && $urandom_range(9) < 6) begin
          value = ring_store[(ring_head + $urandom_range(ring_fill - 1)) % Depth];
        end
      end else if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      issue_command(op, value, 1'b0, STAT_OK, '0);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Depth + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
